FILE: rtl/core/jtdm_pkg.sv
// Shared widths, types and constants for the track drive mixer.
package jtdm_pkg;

  localparam int AXIS_W              = 16;
  localparam int AXIS_FRAC_BITS_DEF  = 15;
  localparam int MOTOR_W             = 10;
  localparam int VALVE_W             = 15;
  localparam int SQ_W                = 31;  // |axis|^2 <= 2^30
  localparam int DEN_W               = 32;  // v^2 + h^2 <= 2^31
  localparam int NUM_W               = 44;  // |v^2 - h^2| * 10000 < 2^44
  localparam int QUO_W               = 14;  // quotient <= 10000
  localparam int MUL_A_W             = 42;
  localparam int MUL_B_W             = 16;
  localparam int PROD_W              = 52;  // den * m * m < 2^52
  localparam int ROOT_IN_W           = 20;
  localparam int ROOT_W              = 10;

  localparam logic [MOTOR_W-1:0] MOTOR_RESET   = MOTOR_W'(200);
  localparam logic [MUL_B_W-1:0] VALVE_FULL_MV = MUL_B_W'(10000);

  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic [MOTOR_W-1:0]        motor_t;
  typedef logic signed [VALVE_W-1:0] valve_t;
  typedef logic signed [1:0]         dpad_t;
  typedef logic [NUM_W-1:0]          num_t;
  typedef logic [DEN_W-1:0]          den_t;
  typedef logic [QUO_W-1:0]          quo_t;

endpackage

FILE: rtl/core/jtdm_if.sv
// Request channel interfaces: gamepad input, drive result and configuration write.
interface jtdm_in_if;
  logic                valid;
  logic                ready;
  jtdm_pkg::axis_t     axis_vertical;
  jtdm_pkg::axis_t     axis_horizontal;
  logic                drive_enable;
  logic                stick_click;
  logic                estop_button;
  logic                cooler_button;
  logic                light_button;
  logic                speed_button;
  jtdm_pkg::dpad_t     dpad_horizontal;
  jtdm_pkg::dpad_t     dpad_vertical;

  modport source (
    output valid, axis_vertical, axis_horizontal, drive_enable, stick_click,
    output estop_button, cooler_button, light_button, speed_button,
    output dpad_horizontal, dpad_vertical,
    input  ready
  );
  modport sink (
    input  valid, axis_vertical, axis_horizontal, drive_enable, stick_click,
    input  estop_button, cooler_button, light_button, speed_button,
    input  dpad_horizontal, dpad_vertical,
    output ready
  );
endinterface

interface jtdm_out_if;
  logic                valid;
  logic                ready;
  logic                estop_on;
  logic                cooler_on;
  logic                light_on;
  logic                speed_valve_on;
  jtdm_pkg::valve_t    left_valve_mv;
  jtdm_pkg::valve_t    right_valve_mv;
  jtdm_pkg::motor_t    motor_command;

  modport source (
    output valid, estop_on, cooler_on, light_on, speed_valve_on,
    output left_valve_mv, right_valve_mv, motor_command,
    input  ready
  );
  modport sink (
    input  valid, estop_on, cooler_on, light_on, speed_valve_on,
    input  left_valve_mv, right_valve_mv, motor_command,
    output ready
  );
endinterface

interface jtdm_cfg_if;
  logic                valid;
  logic                ready;
  jtdm_pkg::motor_t    max_motor_command;

  modport source (output valid, max_motor_command, input ready);
  modport sink   (input valid, max_motor_command, output ready);
endinterface

FILE: rtl/core/joystick_track_drive_mixer.sv
// Track drive mixer top level: latches, shared-multiplier sequencer and result register.
// A report with drive off, stick clicked or stick at zero skips the arithmetic and goes to the
// result stage; a driving report runs the multiplier sequence, skipping the square root when
// the stick radius saturates, then waits for the divider. One report is taken at a time; the
// ten square-root trials on the shared multiplier set the time per report.
// Reset (rst_n low, synchronous): latches clear, max motor command returns to 200, no result.
module joystick_track_drive_mixer #(
  parameter int AXIS_FRACTION_BITS = jtdm_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  jtdm_in_if.sink    in_ch,
  jtdm_out_if.source out_ch,
  jtdm_cfg_if.sink   cfg_ch
);
  import jtdm_pkg::*;

  localparam int FULL_SHIFT = 2 * AXIS_FRACTION_BITS;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_V   = 4'd1;
  localparam logic [3:0] S_MUL_H   = 4'd2;
  localparam logic [3:0] S_SUMS    = 4'd3;
  localparam logic [3:0] S_MUL_N   = 4'd4;
  localparam logic [3:0] S_MUL_DM  = 4'd5;
  localparam logic [3:0] S_MUL_DMM = 4'd6;
  localparam logic [3:0] S_SCALE   = 4'd7;
  localparam logic [3:0] S_SQ_MUL  = 4'd8;
  localparam logic [3:0] S_SQ_CMP  = 4'd9;
  localparam logic [3:0] S_WAIT    = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  // direction quadrants
  localparam logic [1:0] Q_UP_RIGHT   = 2'd0;  // v>0,  h>=0
  localparam logic [1:0] Q_UP_LEFT    = 2'd1;  // v>=0, h<0
  localparam logic [1:0] Q_DOWN_LEFT  = 2'd2;  // v<0,  h<=0
  localparam logic [1:0] Q_DOWN_RIGHT = 2'd3;  // v<=0, h>0

  logic [3:0]           state_r, state_nxt;
  motor_t               max_motor_r;

  // latches
  logic                 estop_r, cooler_r, light_r, speed_r;
  logic                 estop_nxt, cooler_nxt, light_nxt, speed_nxt;

  // per-report working registers
  logic [AXIS_W-1:0]    av_r, ah_r;
  logic [1:0]           quad_r;
  logic                 drive_r;
  logic [SQ_W-1:0]      v2_r;
  den_t                 den_r;
  logic [SQ_W-1:0]      diff_r;
  logic                 kneg_r;
  logic [PROD_W-1:0]    p_r;
  logic [ROOT_IN_W-1:0] x_r;
  logic [ROOT_W-1:0]    sq_q_r, sq_bit_r;
  motor_t               motor_r;

  // result register
  logic                 out_valid_r;
  logic                 o_estop_r, o_cooler_r, o_light_r, o_speed_r;
  valve_t               o_left_r, o_right_r;
  motor_t               o_motor_r;

  // shared multiplier
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [ROOT_W-1:0]    trial;

  // divider hookup
  logic                 div_start, div_busy;
  quo_t                 div_quo;

  logic                 in_fire, out_free;
  logic [AXIS_W-1:0]    av_in, ah_in;
  logic [1:0]           quad_in;
  logic                 drive_in, at_zero;
  logic                 full_hit;
  logic [PROD_W-1:0]    p_scaled;
  logic                 trial_ok;
  valve_t               k_mag, k_val, left_val, right_val;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // magnitudes; -32768 maps to 32768 as unsigned
  assign av_in   = in_ch.axis_vertical[AXIS_W-1]   ? AXIS_W'(-in_ch.axis_vertical)
                                                    : AXIS_W'(in_ch.axis_vertical);
  assign ah_in   = in_ch.axis_horizontal[AXIS_W-1] ? AXIS_W'(-in_ch.axis_horizontal)
                                                    : AXIS_W'(in_ch.axis_horizontal);
  assign at_zero = (in_ch.axis_vertical == '0) && (in_ch.axis_horizontal == '0);
  assign drive_in = in_ch.drive_enable && !in_ch.stick_click && !at_zero;

  always_comb begin
    if (in_ch.axis_vertical > 0 && in_ch.axis_horizontal >= 0) begin
      quad_in = Q_UP_RIGHT;
    end else if (in_ch.axis_vertical >= 0 && in_ch.axis_horizontal < 0) begin
      quad_in = Q_UP_LEFT;
    end else if (in_ch.axis_vertical < 0 && in_ch.axis_horizontal <= 0) begin
      quad_in = Q_DOWN_LEFT;
    end else begin
      quad_in = Q_DOWN_RIGHT;
    end
  end

  // button sets, D-pad clears, button wins; D-pad -2 counts as negative
  always_comb begin
    estop_nxt  = estop_r;
    cooler_nxt = cooler_r;
    light_nxt  = light_r;
    speed_nxt  = speed_r;
    if (in_ch.estop_button) begin
      estop_nxt = 1'b1;
    end else if (in_ch.dpad_horizontal < 0) begin
      estop_nxt = 1'b0;
    end
    if (in_ch.cooler_button) begin
      cooler_nxt = 1'b1;
    end else if (in_ch.dpad_horizontal > 0) begin
      cooler_nxt = 1'b0;
    end
    if (in_ch.light_button) begin
      light_nxt = 1'b1;
    end else if (in_ch.dpad_vertical > 0) begin
      light_nxt = 1'b0;
    end
    if (in_ch.speed_button) begin
      speed_nxt = 1'b1;
    end else if (in_ch.dpad_vertical < 0) begin
      speed_nxt = 1'b0;
    end
  end

  // operand select for the one multiplier; product lands in p_r next cycle
  assign trial = sq_q_r | sq_bit_r;

  always_comb begin
    case (state_r)
      S_MUL_V: begin
        mul_a = MUL_A_W'(av_r);
        mul_b = MUL_B_W'(av_r);
      end
      S_MUL_H: begin
        mul_a = MUL_A_W'(ah_r);
        mul_b = MUL_B_W'(ah_r);
      end
      S_MUL_N: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = VALVE_FULL_MV;
      end
      S_MUL_DM: begin
        mul_a = MUL_A_W'(den_r);
        mul_b = MUL_B_W'(max_motor_r);
      end
      S_MUL_DMM: begin
        mul_a = p_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(max_motor_r);
      end
      S_SQ_MUL: begin
        mul_a = MUL_A_W'(trial);
        mul_b = MUL_B_W'(trial);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // radius >= 1 saturates the motor; otherwise sqrt(den*m*m >> 2F)
  assign full_hit = (den_r >> FULL_SHIFT) != '0;
  assign p_scaled = p_r >> FULL_SHIFT;
  assign trial_ok = p_r[ROOT_IN_W-1:0] <= x_r;

  // divider runs beside the square root; started once |v^2-h^2|*10000 sits in p_r
  assign div_start = (state_r == S_MUL_DM);

  jtdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_r[NUM_W-1:0]),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // valve mix, truncated toward zero
  assign k_mag = VALVE_W'(div_quo);
  assign k_val = kneg_r ? -k_mag : k_mag;

  always_comb begin
    case (quad_r)
      Q_UP_RIGHT: begin
        left_val  = k_val;
        right_val = VALVE_W'(VALVE_FULL_MV);
      end
      Q_UP_LEFT: begin
        left_val  = VALVE_W'(VALVE_FULL_MV);
        right_val = k_val;
      end
      Q_DOWN_LEFT: begin
        left_val  = -k_val;
        right_val = -VALVE_W'(VALVE_FULL_MV);
      end
      default: begin
        left_val  = -VALVE_W'(VALVE_FULL_MV);
        right_val = -k_val;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = drive_in ? S_MUL_V : S_DONE;
        end
      end
      S_MUL_V:   state_nxt = S_MUL_H;
      S_MUL_H:   state_nxt = S_SUMS;
      S_SUMS:    state_nxt = S_MUL_N;
      S_MUL_N:   state_nxt = S_MUL_DM;
      S_MUL_DM:  state_nxt = S_MUL_DMM;
      S_MUL_DMM: state_nxt = S_SCALE;
      S_SCALE:   state_nxt = full_hit ? S_WAIT : S_SQ_MUL;
      S_SQ_MUL:  state_nxt = S_SQ_CMP;
      S_SQ_CMP:  state_nxt = sq_bit_r[0] ? S_WAIT : S_SQ_MUL;
      S_WAIT: begin
        if (!div_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_motor_r <= MOTOR_RESET;
      estop_r     <= 1'b0;
      cooler_r    <= 1'b0;
      light_r     <= 1'b0;
      speed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_motor_r <= cfg_ch.max_motor_command;
      end
      if (in_fire) begin
        estop_r  <= estop_nxt;
        cooler_r <= cooler_nxt;
        light_r  <= light_nxt;
        speed_r  <= speed_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= mul_p[PROD_W-1:0];
    if (in_fire) begin
      av_r    <= av_in;
      ah_r    <= ah_in;
      quad_r  <= quad_in;
      drive_r <= drive_in;
    end
    if (state_r == S_MUL_H) begin
      v2_r <= p_r[SQ_W-1:0];
    end
    if (state_r == S_SUMS) begin
      den_r <= DEN_W'(v2_r) + DEN_W'(p_r[SQ_W-1:0]);
      if (v2_r >= p_r[SQ_W-1:0]) begin
        diff_r <= v2_r - p_r[SQ_W-1:0];
        kneg_r <= 1'b0;
      end else begin
        diff_r <= p_r[SQ_W-1:0] - v2_r;
        kneg_r <= 1'b1;
      end
    end
    if (state_r == S_SCALE) begin
      x_r      <= p_scaled[ROOT_IN_W-1:0];
      sq_q_r   <= '0;
      sq_bit_r <= {1'b1, {(ROOT_W-1){1'b0}}};
      if (full_hit) begin
        motor_r <= max_motor_r;
      end
    end
    if (state_r == S_SQ_CMP) begin
      if (trial_ok) begin
        sq_q_r <= trial;
      end
      sq_bit_r <= sq_bit_r >> 1;
      if (sq_bit_r[0]) begin
        motor_r <= trial_ok ? trial : sq_q_r;
      end
    end
    if (state_r == S_DONE && out_free) begin
      o_estop_r  <= estop_r;
      o_cooler_r <= cooler_r;
      o_light_r  <= light_r;
      o_speed_r  <= speed_r;
      o_left_r   <= drive_r ? left_val  : '0;
      o_right_r  <= drive_r ? right_val : '0;
      o_motor_r  <= drive_r ? motor_r   : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.estop_on       = o_estop_r;
  assign out_ch.cooler_on      = o_cooler_r;
  assign out_ch.light_on       = o_light_r;
  assign out_ch.speed_valve_on = o_speed_r;
  assign out_ch.left_valve_mv  = o_left_r;
  assign out_ch.right_valve_mv = o_right_r;
  assign out_ch.motor_command  = o_motor_r;

endmodule

FILE: rtl/core/jtdm_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module jtdm_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  jtdm_pkg::num_t  num,
  input  jtdm_pkg::den_t  den,
  output logic            busy,
  output jtdm_pkg::quo_t  quo
);
  import jtdm_pkg::*;

  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             ge;

  assign ge = DSH_W'(rem_r) >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(QUO_W-1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r[NUM_W-1:0];
      end
      q_nxt   = {q_r[QUO_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule
